### src/owq_pkg.sv
// Shared types, sizes and codes for the ordered wait queue.
// No dependencies; imported by owq_core, ordered_wait_queue_unit and the bench.
package owq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int ID_W     = 16;
	localparam int PARTY_W  = 8;
	localparam int TEAMS_W  = 7;
	localparam int PEOPLE_W = 14;

	localparam logic [TEAMS_W-1:0]  TEAMS_MAX  = '1;
	localparam logic [PEOPLE_W-1:0] PEOPLE_MAX = '1;

	// request function codes
	localparam logic [2:0] FUNC_RESERVE = 3'd0;
	localparam logic [2:0] FUNC_FIND    = 3'd1;
	localparam logic [2:0] FUNC_CANCEL  = 3'd2;
	localparam logic [2:0] FUNC_DELAY   = 3'd3;
	localparam logic [2:0] FUNC_SERVE   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]         func;
		logic [ID_W-1:0]    wait_id;
		logic [PARTY_W-1:0] party_size;
	} owq_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [ID_W-1:0]     out_id;
		logic [PARTY_W-1:0]  out_party;
		logic [TEAMS_W-1:0]  teams_ahead;
		logic [PEOPLE_W-1:0] people_ahead;
	} owq_rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PARTY_W-1:0] party;
	} owq_entry_t;

	// core status toward the handshake logic
	typedef struct packed {
		logic idle;
		logic done;
	} owq_stat_t;

endpackage

### src/ordered_wait_queue_unit.sv
// Top level of the ordered wait queue: request/result handshakes and
// the result register around owq_core. Depends on owq_pkg and owq_core.
//
// Ordered queue of owq_pkg::QUEUE_DEPTH entries held in a single-port-read,
// single-port-write memory; one request is worked at a time and req_ready
// is low while it runs. Reserve, serve on an empty queue and unknown codes
// finish from idle: the core sets its result as the request is taken, and
// it passes to the result register once that is free. Find, cancel and
// delay scan from the head at one entry per cycle. Cancel and serve then
// close the gap one entry per cycle; delay then reads the next entry and
// writes the pair back swapped. Scans and shifts are paced by the memory's
// one read per cycle. A new request is taken while the previous result
// waits in the output register. No clearing pass after reset: only entries
// below the count are ever used.
module ordered_wait_queue_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  owq_pkg::owq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output owq_pkg::owq_rsp_t rsp
);
	import owq_pkg::*;

	owq_stat_t core_stat;
	owq_rsp_t  core_rsp;
	owq_rsp_t  rsp_q;
	logic      rsp_valid_q;
	logic      start;
	logic      ack;

	assign req_ready = core_stat.idle;
	assign start     = req_valid && req_ready;
	// core hands its result over once the output register is free
	assign ack       = core_stat.done && (!rsp_valid_q || rsp_ready);

	owq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.ack    (ack),
		.stat   (core_stat),
		.rsp    (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ack) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			rsp_q <= core_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### src/owq_core.sv
// Queue storage and the sequencer that scans, shifts and swaps entries
// through one read and one write port. Depends on owq_pkg.
module owq_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  owq_pkg::owq_req_t  req,
	input  logic               ack,
	output owq_pkg::owq_stat_t stat,
	output owq_pkg::owq_rsp_t  rsp
);
	import owq_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_SRV    = 3'd3;
	localparam logic [2:0] S_DLY_RD = 3'd4;
	localparam logic [2:0] S_DLY_W1 = 3'd5;
	localparam logic [2:0] S_DLY_W2 = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	owq_entry_t mem [QUEUE_DEPTH];
	owq_entry_t rdata_q;

	logic [2:0]          state_q;
	logic [2:0]          func_q;
	logic [ID_W-1:0]     key_q;
	logic [CNT_W-1:0]    count_q;
	logic [ID_W-1:0]     id_q;
	logic [CNT_W-1:0]    scan_q;
	logic                rd_vld_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [IDX_W-1:0]    pos_q;
	owq_entry_t          hold_q;
	logic [TEAMS_W-1:0]  teams_q;
	logic [PEOPLE_W-1:0] people_q;
	owq_rsp_t            rsp_q;

	logic [IDX_W-1:0]    raddr;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	owq_entry_t          wdata;
	logic                issue;
	logic                match;
	logic                full;
	logic [ID_W-1:0]     id_next;
	logic [CNT_W-1:0]    next_idx;
	logic [PEOPLE_W:0]   people_sum;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign id_next    = id_q + 1'b1;
	assign issue      = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (scan_q < count_q);
	assign match      = rd_vld_q && (rdata_q.id == key_q);
	assign next_idx   = CNT_W'(rd_idx_q) + CNT_W'(1);
	assign people_sum = {1'b0, people_q} + (PEOPLE_W + 1)'(rdata_q.party);

	always_comb begin
		raddr = scan_q[IDX_W-1:0];
		we    = 1'b0;
		waddr = rd_idx_q - 1'b1;
		wdata = rdata_q;
		unique case (state_q)
			S_IDLE: begin
				// head is read ahead so a serve finds it ready
				raddr    = '0;
				we       = start && (req.func == FUNC_RESERVE) && !full;
				waddr    = count_q[IDX_W-1:0];
				wdata.id = id_next;
				wdata.party = req.party_size;
			end
			S_SHIFT: begin
				we = rd_vld_q;
			end
			S_DLY_RD: begin
				raddr = pos_q + 1'b1;
			end
			S_DLY_W1: begin
				we    = 1'b1;
				waddr = pos_q;
			end
			S_DLY_W2: begin
				we    = 1'b1;
				waddr = pos_q + 1'b1;
				wdata = hold_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			id_q     <= '0;
			rd_vld_q <= 1'b0;
			scan_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q   <= req.func;
						key_q    <= req.wait_id;
						rsp_q    <= '0;
						teams_q  <= '0;
						people_q <= '0;
						rd_vld_q <= 1'b0;
						scan_q   <= '0;
						case (req.func) inside
							FUNC_RESERVE: begin
								if (full) begin
									rsp_q.status <= ST_FULL;
								end else begin
									id_q         <= id_next;
									count_q      <= count_q + 1'b1;
									rsp_q.out_id <= id_next;
									rsp_q.status <= ST_OK;
								end
								state_q <= S_DONE;
							end
							FUNC_FIND, FUNC_CANCEL, FUNC_DELAY: begin
								state_q <= S_SCAN;
							end
							FUNC_SERVE: begin
								if (count_q == '0) begin
									rsp_q.status <= ST_FAIL;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SRV;
								end
							end
							default: begin
								rsp_q.status <= ST_FAIL;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// one read issued per cycle, compared in the next cycle
					rd_vld_q <= issue;
					rd_idx_q <= scan_q[IDX_W-1:0];
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (match) begin
						rd_vld_q <= 1'b0;
						case (func_q)
							FUNC_FIND: begin
								rsp_q.status       <= ST_OK;
								rsp_q.teams_ahead  <= teams_q;
								rsp_q.people_ahead <= people_q;
								state_q            <= S_DONE;
							end
							FUNC_CANCEL: begin
								scan_q  <= next_idx;
								state_q <= S_SHIFT;
							end
							default: begin
								if (next_idx < count_q) begin
									hold_q  <= rdata_q;
									pos_q   <= rd_idx_q;
									state_q <= S_DLY_RD;
								end else begin
									rsp_q.status <= ST_FAIL;
									state_q      <= S_DONE;
								end
							end
						endcase
					end else if (rd_vld_q) begin
						if (teams_q != TEAMS_MAX) begin
							teams_q <= teams_q + 1'b1;
						end
						people_q <= people_sum[PEOPLE_W] ? PEOPLE_MAX
							: people_sum[PEOPLE_W-1:0];
					end else if (!issue) begin
						rsp_q.status <= ST_FAIL;
						state_q      <= S_DONE;
					end
				end
				S_SHIFT: begin
					// read entry i+1, write it to i on the next cycle
					rd_vld_q <= issue;
					rd_idx_q <= scan_q[IDX_W-1:0];
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (!issue && !rd_vld_q) begin
						count_q      <= count_q - 1'b1;
						rsp_q.status <= ST_OK;
						state_q      <= S_DONE;
					end
				end
				S_SRV: begin
					rsp_q.out_id    <= rdata_q.id;
					rsp_q.out_party <= rdata_q.party;
					scan_q          <= CNT_W'(1);
					rd_vld_q        <= 1'b0;
					state_q         <= S_SHIFT;
				end
				S_DLY_RD: begin
					state_q <= S_DLY_W1;
				end
				S_DLY_W1: begin
					state_q <= S_DLY_W2;
				end
				S_DLY_W2: begin
					rsp_q.status <= ST_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1
			|| count_q == $past(count_q) - 1'b1))
		else $error("entry count moved by more than one");

	a_rd_vld_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> (state_q == S_SCAN || state_q == S_SHIFT))
		else $error("read in flight outside scan or shift");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("request started while busy");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !ack) |=> (state_q == S_DONE && $stable(rsp_q)))
		else $error("finished result changed before hand-off");

endmodule

### dv/ordered_wait_queue_unit_tb.sv
// Self-checking bench for ordered_wait_queue_unit: random and directed requests
// against a queue model held in a small scoreboard class. Depends on owq_pkg and the RTL.
module ordered_wait_queue_unit_tb;
	import owq_pkg::*;

	localparam int CYCLE_LIMIT   = 5_000_000;
	localparam int LINGER_CYCLES = 4 * QUEUE_DEPTH + 50;
	localparam int RANDOM_ITEMS  = 680;
	localparam int REPORT_CAP    = 100;

	// func codes the block does not define
	localparam logic [2:0] FUNC_BAD_FIRST = 3'd5;
	localparam logic [2:0] FUNC_BAD_MID   = 3'd6;
	localparam logic [2:0] FUNC_BAD_LAST  = 3'd7;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

	class queue_scoreboard;
		owq_entry_t      waiting[$];
		logic [ID_W-1:0] last_id;
		owq_rsp_t        awaited[$];
		int              errors;

		function new();
			last_id = '0;
			errors  = 0;
		endfunction

		function int locate(logic [ID_W-1:0] key);
			for (int i = 0; i < waiting.size(); i++) begin
				if (waiting[i].id == key)
					return i;
			end
			return waiting.size();
		endfunction

		// updates the queue copy and returns the result the request must give
		function owq_rsp_t apply_request(owq_req_t r);
			owq_rsp_t   res;
			owq_entry_t ent;
			int         pos;
			int         teams;
			int         people;
			res        = '0;
			res.status = ST_FAIL;
			pos        = locate(r.wait_id);
			teams      = 0;
			people     = 0;
			case (r.func)
				FUNC_RESERVE: begin
					if (waiting.size() >= QUEUE_DEPTH) begin
						res.status = ST_FULL;
					end else begin
						last_id   = last_id + 1'b1;
						ent.id    = last_id;
						ent.party = r.party_size;
						waiting.push_back(ent);
						res.out_id = last_id;
						res.status = ST_OK;
					end
				end
				FUNC_FIND: begin
					if (pos < waiting.size()) begin
						for (int i = 0; i < pos; i++) begin
							if (teams < TEAMS_MAX)
								teams++;
							people += waiting[i].party;
							if (people > PEOPLE_MAX)
								people = PEOPLE_MAX;
						end
						res.teams_ahead  = TEAMS_W'(teams);
						res.people_ahead = PEOPLE_W'(people);
						res.status       = ST_OK;
					end
				end
				FUNC_CANCEL: begin
					if (pos < waiting.size()) begin
						waiting.delete(pos);
						res.status = ST_OK;
					end
				end
				FUNC_DELAY: begin
					if (pos + 1 < waiting.size()) begin
						ent              = waiting[pos];
						waiting[pos]     = waiting[pos + 1];
						waiting[pos + 1] = ent;
						res.status       = ST_OK;
					end
				end
				FUNC_SERVE: begin
					if (waiting.size() > 0) begin
						ent           = waiting.pop_front();
						res.out_id    = ent.id;
						res.out_party = ent.party;
						res.status    = ST_OK;
					end
				end
				default: begin
				end
			endcase
			return res;
		endfunction

		function void note_request(owq_req_t r);
			awaited.push_back(apply_request(r));
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				if (errors < REPORT_CAP)
					$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(owq_rsp_t got);
			owq_rsp_t want;
			if (awaited.size() == 0) begin
				if (errors < REPORT_CAP)
					$error("result with no request outstanding: %p", got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("out_id", 32'(want.out_id), 32'(got.out_id));
			check_field("out_party", 32'(want.out_party), 32'(got.out_party));
			check_field("teams_ahead", 32'(want.teams_ahead), 32'(got.teams_ahead));
			check_field("people_ahead", 32'(want.people_ahead), 32'(got.people_ahead));
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	owq_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	owq_rsp_t rsp;

	queue_scoreboard sb;
	logic            receiver_stalls = 1'b1;
	bit              sender_gaps = 1'b1;
	int              burst_left = 0;
	int              ready_left = 0;
	int              cycles = 0;

	ordered_wait_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: with stalls enabled, ready runs alternate with stalls, occasionally a long one
	always @(posedge clk) begin
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else if (!receiver_stalls || !rsp_ready) begin
			rsp_ready  <= 1'b1;
			ready_left <= $urandom_range(0, 24);
		end else begin
			rsp_ready  <= 1'b0;
			ready_left <= ($urandom_range(0, 15) == 0) ? 40 : $urandom_range(0, 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
	end

	function automatic owq_req_t make_req(logic [2:0] f, logic [ID_W-1:0] id,
			logic [PARTY_W-1:0] p);
		owq_req_t r;
		r.func       = f;
		r.wait_id    = id;
		r.party_size = p;
		return r;
	endfunction

	function automatic owq_req_t random_request(traffic_mode_t mode);
		int                 roll;
		int                 n;
		logic [2:0]         f;
		logic [ID_W-1:0]    id;
		logic [PARTY_W-1:0] p;
		n    = sb.waiting.size();
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				f = roll < 72 ? FUNC_RESERVE : roll < 84 ? FUNC_FIND :
					roll < 92 ? FUNC_DELAY : roll < 96 ? FUNC_CANCEL : FUNC_SERVE;
			end
			MODE_DRAIN: begin
				f = roll < 10 ? FUNC_RESERVE : roll < 30 ? FUNC_FIND :
					roll < 45 ? FUNC_DELAY : roll < 70 ? FUNC_CANCEL : FUNC_SERVE;
			end
			default: begin
				f = roll < 30 ? FUNC_RESERVE : roll < 55 ? FUNC_FIND :
					roll < 70 ? FUNC_DELAY : roll < 85 ? FUNC_CANCEL : FUNC_SERVE;
			end
		endcase
		if ($urandom_range(0, 99) < 3)
			f = 3'($urandom_range(FUNC_BAD_FIRST, FUNC_BAD_LAST));
		// mostly ids that are waiting, some misses and raw noise
		roll = $urandom_range(0, 99);
		if (n > 0 && roll < 85)
			id = sb.waiting[$urandom_range(0, n - 1)].id;
		else if (roll < 92)
			id = sb.last_id + 1'b1;
		else
			id = ID_W'($urandom());
		roll = $urandom_range(0, 99);
		p = roll < 20 ? 8'hFF : roll < 30 ? 8'h00 : PARTY_W'($urandom());
		return make_req(f, id, p);
	endfunction

	task automatic issue(input owq_req_t r);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_ready !== 1'b1);
		sb.note_request(r);
		if (sender_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				req_valid <= 1'b0;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
						$urandom_range(1, 4))
					@(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		traffic_mode_t   mode;
		int              sent;
		int              seg;
		int              seg_len;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, unused codes, then a three-entry walk through every function
		issue(make_req(FUNC_SERVE, 16'h0000, 8'h00));
		issue(make_req(FUNC_FIND, 16'h0000, 8'hFF));
		issue(make_req(FUNC_CANCEL, 16'hFFFF, 8'h00));
		issue(make_req(FUNC_DELAY, 16'h0000, 8'h00));
		issue(make_req(FUNC_BAD_FIRST, 16'hFFFF, 8'hFF));
		issue(make_req(FUNC_BAD_MID, 16'h5A5A, 8'hA5));
		issue(make_req(FUNC_BAD_LAST, 16'h0001, 8'h00));
		issue(make_req(FUNC_RESERVE, 16'hFFFF, 8'h00));
		issue(make_req(FUNC_RESERVE, 16'h0000, 8'hFF));
		issue(make_req(FUNC_RESERVE, 16'h1234, 8'h01));
		issue(make_req(FUNC_FIND, 16'd3, 8'h00));
		issue(make_req(FUNC_FIND, 16'd1, 8'h00));
		issue(make_req(FUNC_FIND, 16'hFFFF, 8'h00));
		issue(make_req(FUNC_DELAY, 16'd3, 8'h00));
		issue(make_req(FUNC_DELAY, 16'd1, 8'h00));
		issue(make_req(FUNC_FIND, 16'd1, 8'h00));
		issue(make_req(FUNC_CANCEL, 16'd2, 8'h00));
		issue(make_req(FUNC_CANCEL, 16'd2, 8'h00));
		issue(make_req(FUNC_SERVE, 16'h0000, 8'h00));
		issue(make_req(FUNC_SERVE, 16'h0000, 8'h00));
		issue(make_req(FUNC_SERVE, 16'h0000, 8'h00));

		// segments of biased traffic; the first one runs the queue into full
		sent = 0;
		seg  = 0;
		while (sent < RANDOM_ITEMS) begin
			mode    = (seg == 0) ? MODE_FILL : traffic_mode_t'($urandom_range(0, 2));
			seg_len = (seg == 0) ? 120 : $urandom_range(30, 80);
			sender_gaps = ($urandom_range(0, 4) != 0);
			receiver_stalls <= ($urandom_range(0, 3) != 0);
			if (seg == 3)
				wait_drained();
			repeat (seg_len) begin
				issue(random_request(mode));
				sent++;
			end
			seg++;
		end

		wait_drained();
		repeat (LINGER_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
